FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the list unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: rtl/core/slid_pkg.sv
// Shared codes, port widths and controller/datapath interface types of the list unit.
package slid_pkg;

    // Fixed field widths of the transaction ports
    localparam int OP_W       = 2;
    localparam int POS_W      = 8;
    localparam int CNT_W      = 8;
    localparam int IO_VALUE_W = 32;
    localparam int STATUS_W   = 2;
    localparam int LEN_OUT_W  = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // latch the accepted transaction
        logic check;       // latch status, arm the shift counters
        logic rd_issue;    // read the entry at the position
        logic rd_capture;  // move read data to the result register
        logic place;       // write the insert value, grow the list
        logic shrink;      // drop the deleted entries from the length
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [STATUS_W-1:0] chk_status;
        logic                is_insert;
        logic                is_read;
        logic                shift_idle;
    } t_dp_sts;

endpackage

FILE: rtl/core/slid_ctrl.sv
// Controller state machine of the list unit: sequences check, shift, place and read.
module slid_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_done,
    output slid_pkg::t_dp_cmd o_cmd,
    input  slid_pkg::t_dp_sts i_sts
);
    import slid_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT,
        S_RDCAP
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   r_done;

    // Decode next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.chk_status != ST_OK) begin
                    n_state = S_IDLE;
                end else if (i_sts.is_read) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_RDCAP;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_idle) begin
                    if (i_sts.is_insert) begin
                        o_cmd.place = 1'b1;
                    end else begin
                        o_cmd.shrink = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_RDCAP: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, busy flag and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_done  <= (r_state != S_IDLE) && (n_state == S_IDLE);
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;

`include "assert_macros.svh"

    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (start && !r_busy) |=> r_busy, "busy not raised")
    `ASSERT_NEVER(a_done_busy, i_clk, i_rst_n, r_done && r_busy, "result while busy")
    `ASSERT_CLK(a_done_after_work, i_clk, i_rst_n, r_done |-> $past(r_busy), "stray result")

endmodule

FILE: rtl/core/slid_datapath.sv
// Datapath of the list unit: entry memory, length, checks, shift pipeline, result registers.
module slid_datapath #(
    parameter int CAPACITY    = 128,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  slid_pkg::t_dp_cmd                         i_cmd,
    output slid_pkg::t_dp_sts                         o_sts,
    input  logic [slid_pkg::OP_W-1:0]                 i_op,
    input  logic [slid_pkg::POS_W-1:0]                i_position,
    input  logic [slid_pkg::CNT_W-1:0]                i_count,
    input  logic signed [slid_pkg::IO_VALUE_W-1:0]    i_value,
    output logic [slid_pkg::STATUS_W-1:0]             o_status,
    output logic signed [slid_pkg::IO_VALUE_W-1:0]    o_read_value,
    output logic [slid_pkg::LEN_OUT_W-1:0]            o_list_length
);
    import slid_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int LW  = $clog2(CAPACITY + 1);
    localparam int CW  = ((LW > POS_W + 1) ? LW : POS_W + 1) + 1;
    localparam int XW  = (VALUE_WIDTH > IO_VALUE_W) ? VALUE_WIDTH : IO_VALUE_W;

    // Entry memory, one write and one registered read per cycle
    logic [VALUE_WIDTH-1:0] r_mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_rdata;

    // Latched transaction
    logic [OP_W-1:0]        r_op;
    logic [POS_W-1:0]       r_pos;
    logic [CNT_W-1:0]       r_cnt;
    logic [VALUE_WIDTH-1:0] r_val;

    // List length and shift pipeline
    logic [LW-1:0]          r_len;
    logic [LW-1:0]          r_left;
    logic [AW-1:0]          r_ra;
    logic [AW-1:0]          r_wa;
    logic                   r_wvld;

    // Result registers
    logic [STATUS_W-1:0]          r_status;
    logic signed [IO_VALUE_W-1:0] r_read_value;

    logic [CW-1:0]          pos_x, cnt_x, len_x;
    logic                   pos_zero;
    logic                   ins_bad, del_bad, rd_bad, list_full;
    logic [STATUS_W-1:0]    chk_status;
    logic                   is_insert, is_read, is_shift_op;
    logic [LW-1:0]          left_init;
    logic [AW-1:0]          ra_init;
    logic [AW-1:0]          pos_idx;
    logic [AW-1:0]          mem_ra, mem_wa;
    logic [VALUE_WIDTH-1:0] mem_wd;
    logic                   mem_we;
    logic signed [XW-1:0]   rd_ext;

    // Range checks on the latched transaction
    assign pos_x     = CW'(r_pos);
    assign cnt_x     = CW'(r_cnt);
    assign len_x     = CW'(r_len);
    assign pos_zero  = (r_pos == '0);
    assign ins_bad   = pos_zero || (pos_x > len_x + CW'(1));
    assign list_full = (len_x == CW'(CAPACITY));
    assign rd_bad    = pos_zero || (pos_x > len_x);
    assign del_bad   = rd_bad || (pos_x + cnt_x - CW'(1) > len_x);
    assign is_insert = (r_op == OP_INSERT);
    assign is_read   = (r_op == OP_READ);

    always_comb begin
        unique case (r_op)
            OP_INSERT: chk_status = ins_bad ? ST_BAD : (list_full ? ST_FULL : ST_OK);
            OP_DELETE: chk_status = del_bad ? ST_BAD : ST_OK;
            OP_READ:   chk_status = rd_bad ? ST_BAD : ST_OK;
            default:   chk_status = ST_BAD;
        endcase
    end

    // Shift span: insert moves tail up from the top, delete moves tail down from the cut
    assign is_shift_op = (r_op == OP_INSERT) || (r_op == OP_DELETE);
    assign left_init   = is_insert ? LW'(len_x - pos_x + CW'(1))
                                   : LW'(len_x + CW'(1) - pos_x - cnt_x);
    assign ra_init     = is_insert ? AW'(len_x - CW'(1))
                                   : AW'(pos_x + cnt_x - CW'(1));
    assign pos_idx     = AW'(pos_x - CW'(1));

    // Memory port selection
    assign mem_ra = i_cmd.rd_issue ? pos_idx : r_ra;
    assign mem_we = r_wvld || i_cmd.place;
    assign mem_wa = i_cmd.place ? pos_idx : r_wa;
    assign mem_wd = i_cmd.place ? r_val : r_rdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    // Latch transaction fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_pos <= i_position;
            r_cnt <= i_count;
            r_val <= VALUE_WIDTH'(i_value);
        end
    end

    // Advance the shift pipeline, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_wvld <= 1'b0;
        end else begin
            r_wvld <= (r_left != '0);
            if (i_cmd.check) begin
                r_left <= (chk_status == ST_OK && is_shift_op) ? left_init : '0;
            end else if (r_left != '0) begin
                r_left <= r_left - LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_ra <= ra_init;
        end else if (r_left != '0) begin
            r_ra <= is_insert ? r_ra - AW'(1) : r_ra + AW'(1);
        end
        r_wa <= is_insert ? r_ra + AW'(1) : r_ra - AW'(r_cnt);
    end

    // Update the list length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.place) begin
            r_len <= r_len + LW'(1);
        end else if (i_cmd.shrink) begin
            r_len <= r_len - LW'(r_cnt);
        end
    end

    // Result registers
    assign rd_ext = XW'($signed(r_rdata));

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_status     <= chk_status;
            r_read_value <= '0;
        end else if (i_cmd.rd_capture) begin
            r_read_value <= rd_ext[IO_VALUE_W-1:0];
        end
    end

    assign o_sts.chk_status = chk_status;
    assign o_sts.is_insert  = is_insert;
    assign o_sts.is_read    = is_read;
    assign o_sts.shift_idle = (r_left == '0) && !r_wvld;

    assign o_status      = r_status;
    assign o_read_value  = r_read_value;
    assign o_list_length = LEN_OUT_W'(r_len);

`include "assert_macros.svh"

    `ASSERT_CLK(a_len_cap, i_clk, i_rst_n, r_len <= LW'(CAPACITY), "length above capacity")
    `ASSERT_CLK(a_place_drained, i_clk, i_rst_n, i_cmd.place |-> (!r_wvld && r_left == '0), "place during shift")
    `ASSERT_CLK(a_shrink_fits, i_clk, i_rst_n, i_cmd.shrink |-> (cnt_x <= len_x), "shrink below zero")

endmodule

FILE: rtl/core/sequential_list_insert_delete_unit.sv
// Top level of the packed list unit: positional insert, range delete and read.
//
//  Channel   Handshake           Fields
//  --------  ------------------  --------------------------------------------
//  command   start & !busy       i_op, i_position, i_count, i_value
//  result    o_done (1 cycle)    o_status, o_read_value, o_list_length
//
// One transaction at a time; each gives exactly one result.
// Insert and delete move M entries through the entry memory, one per cycle
// (M = length-position+1 for insert, length-position-count+1 for delete), before
// the result strobes; reads and errors move none. busy falls in the cycle the
// result strobes. Reset clears the length; entries are undefined until written.
// No output stall.
module sequential_list_insert_delete_unit #(
    parameter int CAPACITY    = 128,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [slid_pkg::OP_W-1:0]              i_op,
    input  logic [slid_pkg::POS_W-1:0]             i_position,
    input  logic [slid_pkg::CNT_W-1:0]             i_count,
    input  logic signed [slid_pkg::IO_VALUE_W-1:0] i_value,
    output logic                                   o_done,
    output logic [slid_pkg::STATUS_W-1:0]          o_status,
    output logic signed [slid_pkg::IO_VALUE_W-1:0] o_read_value,
    output logic [slid_pkg::LEN_OUT_W-1:0]         o_list_length
);
    import slid_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequence the transaction
    slid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (dp_cmd),
        .i_sts   (dp_sts)
    );

    // Hold the list and compute results
    slid_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_op          (i_op),
        .i_position    (i_position),
        .i_count       (i_count),
        .i_value       (i_value),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_list_length (o_list_length)
    );

endmodule
